// ----- rtl/sid_pkg.sv -----
// Types and constants shared by the signed integer divider core.
// No dependencies; imported by every module of the block.
`default_nettype none

package sid_pkg;

   localparam int DATA_WIDTH = 32;
   localparam int COUNT_WIDTH = $clog2(DATA_WIDTH);

   localparam logic signed [DATA_WIDTH-1:0] INT_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};

   typedef struct packed {
      logic signed [DATA_WIDTH-1:0] dividend;
      logic signed [DATA_WIDTH-1:0] divisor;
   } sid_req_type;

   typedef struct packed {
      logic signed [DATA_WIDTH-1:0] quotient;
      logic                         overflow;
      logic                         divide_by_zero;
   } sid_rsp_type;

   typedef struct packed {
      logic load;
      logic step;
      logic finish;
   } sid_cmd_type;

endpackage

`default_nettype wire

// ----- rtl/sid_datapath.sv -----
// Datapath of the divider: operand magnitudes, restoring shift-subtract
// iteration, sign fix-up and the result register. Depends on sid_pkg.
`default_nettype none

module sid_datapath
   import sid_pkg::*;
(
   input  wire               clock,
   input  wire sid_cmd_type  cmd,
   input  wire sid_req_type  req_payload,
   output sid_rsp_type       rsp_payload
);

   logic [DATA_WIDTH-1:0] rem_ff, rem_in;
   logic [DATA_WIDTH-1:0] quo_ff, quo_in;
   logic [DATA_WIDTH-1:0] div_ff, div_in;
   logic                  neg_ff, neg_in;
   logic                  dz_ff, dz_in;
   sid_rsp_type           out_ff, out_in;

   logic [DATA_WIDTH:0]   partial;
   logic [DATA_WIDTH:0]   diff;

   always_comb begin
      partial = {rem_ff, quo_ff[DATA_WIDTH-1]};
      diff    = partial - {1'b0, div_ff};

      rem_in = rem_ff;
      quo_in = quo_ff;
      div_in = div_ff;
      neg_in = neg_ff;
      dz_in  = dz_ff;
      out_in = out_ff;

      if (cmd.load) begin
         rem_in = '0;
         quo_in = req_payload.dividend[DATA_WIDTH-1] ?
                  DATA_WIDTH'(-req_payload.dividend) : DATA_WIDTH'(req_payload.dividend);
         div_in = req_payload.divisor[DATA_WIDTH-1] ?
                  DATA_WIDTH'(-req_payload.divisor) : DATA_WIDTH'(req_payload.divisor);
         neg_in = req_payload.dividend[DATA_WIDTH-1] ^ req_payload.divisor[DATA_WIDTH-1];
         dz_in  = (req_payload.divisor == '0);
      end else if (cmd.step) begin
         // A borrow out of the trial subtraction means this quotient bit is zero.
         rem_in = diff[DATA_WIDTH] ? partial[DATA_WIDTH-1:0] : diff[DATA_WIDTH-1:0];
         quo_in = {quo_ff[DATA_WIDTH-2:0], ~diff[DATA_WIDTH]};
      end

      if (cmd.finish) begin
         out_in.overflow       = 1'b0;
         out_in.divide_by_zero = dz_ff;
         if (dz_ff) begin
            out_in.quotient = '0;
         end else if (neg_ff) begin
            out_in.quotient = -$signed(quo_ff);
         end else if (quo_ff[DATA_WIDTH-1]) begin
            // Only the most negative value divided by minus one lands here.
            out_in.quotient = INT_MAX;
            out_in.overflow = 1'b1;
         end else begin
            out_in.quotient = $signed(quo_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      div_ff <= div_in;
      neg_ff <= neg_in;
      dz_ff  <= dz_in;
      out_ff <= out_in;
   end

   assign rsp_payload = out_ff;

endmodule

`default_nettype wire

// ----- rtl/sid_controller.sv -----
// Controller of the divider: request and response handshakes, iteration
// count and datapath commands. Depends on sid_pkg.
`default_nettype none

module sid_controller
   import sid_pkg::*;
(
   input  wire          clock,
   input  wire          reset,
   input  wire          req_valid,
   output logic         req_ready,
   output logic         rsp_valid,
   input  wire          rsp_ready,
   output sid_cmd_type  cmd
);

   typedef enum logic [1:0] {
      IDLE_ST,
      RUN_ST,
      FIX_ST
   } state_type;

   state_type              state_ff;
   logic [COUNT_WIDTH-1:0] count_ff;
   logic                   rsp_valid_ff;

   localparam logic [COUNT_WIDTH-1:0] LAST_COUNT = COUNT_WIDTH'(DATA_WIDTH - 1);

   always_comb begin
      req_ready  = (state_ff == IDLE_ST);
      cmd.load   = req_valid && req_ready;
      cmd.step   = (state_ff == RUN_ST);
      cmd.finish = (state_ff == FIX_ST) && (!rsp_valid_ff || rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE_ST;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // A finish in the cycle the old response leaves keeps valid high.
         if (cmd.finish) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            IDLE_ST: begin
               if (cmd.load) begin
                  state_ff <= RUN_ST;
                  count_ff <= '0;
               end
            end
            RUN_ST: begin
               count_ff <= count_ff + 1'b1;
               if (count_ff == LAST_COUNT) begin
                  state_ff <= FIX_ST;
               end
            end
            FIX_ST: begin
               // The result register is written only once the previous response is gone.
               if (cmd.finish) begin
                  state_ff <= IDLE_ST;
               end
            end
            default: begin
               state_ff <= IDLE_ST;
            end
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;

   a_load_starts_run: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> (state_ff == RUN_ST) && (count_ff == '0))
      else $error("accepted request did not start the iteration");

   a_finish_sets_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |=> rsp_valid_ff && (state_ff == IDLE_ST))
      else $error("finished division did not present a response");

   a_step_only_when_busy: assert property (@(posedge clock) disable iff (reset)
      cmd.step |-> !req_ready && !cmd.finish)
      else $error("iteration step overlaps idle or finish");

endmodule

`default_nettype wire

// ----- rtl/signed_integer_divider_core.sv -----
// Top level of the signed integer divider: controller plus datapath.
// Depends on sid_pkg, sid_controller and sid_datapath.
`default_nettype none

// Channel   Ports                               Payload
// request   req_valid, req_ready, req_payload   dividend, divisor
// response  rsp_valid, rsp_ready, rsp_payload   quotient, overflow, divide_by_zero
//
// Each request passes from acceptance to response through one load step, one
// restoring shift-subtract step per quotient bit (DATA_WIDTH of them) and one
// sign fix-up step, held by a stalled response, that writes the result register.
// One request is in flight at a time; a new one is accepted as soon as the
// previous one reaches the result register, even while that response stalls.
// Reset is synchronous and clears the controller and the response valid.

module signed_integer_divider_core
   import sid_pkg::*;
(
   input  wire               clock,
   input  wire               reset,
   input  wire               req_valid,
   output logic              req_ready,
   input  wire sid_req_type  req_payload,
   output logic              rsp_valid,
   input  wire               rsp_ready,
   output sid_rsp_type       rsp_payload
);

   sid_cmd_type cmd;

   sid_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   sid_datapath u_dp (
      .clock       (clock),
      .cmd         (cmd),
      .req_payload (req_payload),
      .rsp_payload (rsp_payload)
   );

   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_payload.overflow && rsp_payload.divide_by_zero))
      else $error("overflow and divide-by-zero raised together");

   a_zero_divisor_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.divide_by_zero |-> rsp_payload.quotient == '0)
      else $error("zero divisor gave a nonzero quotient");

   a_overflow_saturates: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.overflow |-> rsp_payload.quotient == INT_MAX)
      else $error("overflow without saturated quotient");

endmodule

`default_nettype wire
